// ----- design/mpp_pkg.sv -----
// Shared types and constants of the midpoint parabola plotter.
package mpp_pkg;

   // Widths of the transfer fields and of the internal decision term (DEC_W); these are fixed by the interface.
   localparam int unsigned VERTEX_W   = 10;
   localparam int unsigned FOCAL_W    = 8;
   localparam int unsigned TAIL_W     = 10;
   localparam int unsigned OUT_W      = 12;
   localparam int unsigned DEC_W      = 32;

   // Defaults and limits.
   localparam int unsigned MPP_COORD_WIDTH = 12;
   localparam logic [TAIL_W-1:0] TAIL_STEPS_RESET = TAIL_W'(100);
   localparam logic [TAIL_W-1:0] TAIL_COUNT_MAX   = '1;

   typedef struct packed {
      logic                start_req;
      logic [VERTEX_W-1:0] vertex_x;
      logic [VERTEX_W-1:0] vertex_y;
      logic [FOCAL_W-1:0]  focal;
   } req_payload_type;

   typedef struct packed {
      logic                    point_valid;
      logic signed [OUT_W-1:0] x_right;
      logic signed [OUT_W-1:0] x_left;
      logic signed [OUT_W-1:0] y_coord;
      logic                    region;
      logic                    last;
   } rsp_payload_type;

endpackage

// ----- design/mpp_if.sv -----
// Valid/ready channel interfaces for the request and response transfers.
interface mpp_req_if;
   logic                     valid;
   logic                     ready;
   mpp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mpp_rsp_if;
   logic                     valid;
   logic                     ready;
   mpp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/mpp_stepper.sv -----
// Curve state and the combinational midpoint step that produces one point pair.
module mpp_stepper #(
   parameter int unsigned COORD_WIDTH = mpp_pkg::MPP_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_fire,
   input  mpp_pkg::req_payload_type      step_req,
   input  logic [mpp_pkg::TAIL_W-1:0]    tail_steps,
   output mpp_pkg::rsp_payload_type      step_rsp
);
   import mpp_pkg::*;

   localparam int unsigned EXT_W = (COORD_WIDTH > OUT_W) ? COORD_WIDTH : OUT_W;

   logic                    active_ff, active_in;
   logic                    in_r2_ff, in_r2_in;
   logic [COORD_WIDTH-1:0]  x_off_ff, x_off_in;
   logic [COORD_WIDTH-1:0]  y_off_ff, y_off_in;
   logic signed [DEC_W-1:0] decision_ff, decision_in;
   logic [TAIL_W-1:0]       tail_count_ff, tail_count_in;
   logic [VERTEX_W-1:0]     vx_ff, vx_in;
   logic [VERTEX_W-1:0]     vy_ff, vy_in;
   logic [FOCAL_W-1:0]      focal_ff, focal_in;

   logic signed [DEC_W-1:0] a_s;
   logic signed [DEC_W-1:0] x_s;
   logic [COORD_WIDTH-1:0]  twice_a;
   logic [TAIL_W-1:0]       tail_eff;
   logic                    idle_step;
   logic                    region_out;
   logic                    last_out;
   logic [COORD_WIDTH-1:0]  xr_sum, xl_sum, y_sum;
   logic [EXT_W-1:0]        xr_ext, xl_ext, y_ext;

   assign a_s      = signed'(DEC_W'(focal_ff));
   assign x_s      = signed'(DEC_W'(x_off_ff));
   assign twice_a  = COORD_WIDTH'({focal_ff, 1'b0});
   assign tail_eff = (tail_steps == '0) ? TAIL_W'(1) : tail_steps;

   always_comb begin
      active_in     = active_ff;
      in_r2_in      = in_r2_ff;
      x_off_in      = x_off_ff;
      y_off_in      = y_off_ff;
      decision_in   = decision_ff;
      tail_count_in = tail_count_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      focal_in      = focal_ff;
      idle_step     = 1'b0;
      region_out    = 1'b0;
      last_out      = 1'b0;

      if (step_req.start_req) begin
         vx_in         = step_req.vertex_x;
         vy_in         = step_req.vertex_y;
         focal_in      = step_req.focal;
         x_off_in      = '0;
         y_off_in      = '0;
         decision_in   = DEC_W'(32'sd1) - signed'(DEC_W'({step_req.focal, 1'b0}));
         active_in     = 1'b1;
         in_r2_in      = 1'b0;
         tail_count_in = '0;
      end else if (!active_ff) begin
         idle_step = 1'b1;
      end else begin
         if (!in_r2_ff) begin
            // First region: x always advances, y follows the decision sign.
            if (decision_ff > 0) begin
               decision_in = decision_ff + (x_s <<< 1) + DEC_W'(32'sd3) - (a_s <<< 2);
               y_off_in    = y_off_ff + COORD_WIDTH'(1);
            end else begin
               decision_in = decision_ff + (x_s <<< 1) + DEC_W'(32'sd3);
            end
            x_off_in = x_off_ff + COORD_WIDTH'(1);
            if (x_off_in > twice_a) begin
               // Second region restarts at offset (2a, a).
               in_r2_in      = 1'b1;
               x_off_in      = twice_a;
               y_off_in      = COORD_WIDTH'(focal_ff);
               decision_in   = DEC_W'(32'sd1) - (a_s <<< 3);
               tail_count_in = TAIL_W'(1);
            end
         end else begin
            // Second region: y always advances, x follows the decision sign.
            if (decision_ff < 0) begin
               decision_in = decision_ff + (x_s <<< 3) + DEC_W'(32'sd8) - (a_s <<< 4);
               x_off_in    = x_off_ff + COORD_WIDTH'(1);
            end else begin
               decision_in = decision_ff - (a_s <<< 4);
            end
            y_off_in = y_off_ff + COORD_WIDTH'(1);
            if (tail_count_ff != TAIL_COUNT_MAX) begin
               tail_count_in = tail_count_ff + TAIL_W'(1);
            end
         end
         if (in_r2_in) begin
            region_out = 1'b1;
            if (tail_count_in >= tail_eff) begin
               active_in = 1'b0;
               last_out  = 1'b1;
            end
         end
      end
   end

   // Coordinates wrap in the internal width and are then sign-extended or
   // truncated to the output width.
   assign xr_sum = COORD_WIDTH'(vx_in) + x_off_in;
   assign xl_sum = COORD_WIDTH'(vx_in) - x_off_in;
   assign y_sum  = COORD_WIDTH'(vy_in) + y_off_in;
   assign xr_ext = EXT_W'(signed'(xr_sum));
   assign xl_ext = EXT_W'(signed'(xl_sum));
   assign y_ext  = EXT_W'(signed'(y_sum));

   always_comb begin
      if (idle_step) begin
         step_rsp = '0;
      end else begin
         step_rsp.point_valid = 1'b1;
         step_rsp.x_right     = signed'(xr_ext[OUT_W-1:0]);
         step_rsp.x_left      = signed'(xl_ext[OUT_W-1:0]);
         step_rsp.y_coord     = signed'(y_ext[OUT_W-1:0]);
         step_rsp.region      = region_out;
         step_rsp.last        = last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         in_r2_ff  <= 1'b0;
      end else if (step_fire) begin
         active_ff <= active_in;
         in_r2_ff  <= in_r2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         x_off_ff      <= x_off_in;
         y_off_ff      <= y_off_in;
         decision_ff   <= decision_in;
         tail_count_ff <= tail_count_in;
         vx_ff         <= vx_in;
         vy_ff         <= vy_in;
         focal_ff      <= focal_in;
      end
   end

endmodule

// ----- design/midpoint_parabola_plotter.sv -----
// Top level of the midpoint parabola plotter: channel registers and configuration.
//
// The plotter rasterizes an upward parabola about a vertex and returns one
// mirrored point pair for every request transfer. A request with start_req
// set latches the vertex and focal distance and returns the vertex point;
// each request with start_req clear advances the curve by one point. The
// region-one part runs while the x offset is at most twice the focal
// distance, then region two plots csr-programmed tail_steps points (one when
// tail_steps is 0), and the final one carries last. A step after the curve ends returns point_valid 0.
// csr_wr_en/csr_wr_data write tail_steps (reset value 100); write it only
// while no request is in flight.
// A request is captured in the input register, stepped by one short pass of
// adders and compares once the response register is free, and shown in the
// response register; while the receiver does not stall, one transfer per
// cycle is sustained in both directions.
// Synchronous reset empties both registers and leaves the plotter with no
// active curve. When the receiver stalls, the response register holds and
// the input register still takes one more request before req ready drops.
module midpoint_parabola_plotter #(
   parameter int unsigned COORD_WIDTH = mpp_pkg::MPP_COORD_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   mpp_req_if.sink                    req_chan,
   mpp_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [mpp_pkg::TAIL_W-1:0] csr_wr_data
);
   import mpp_pkg::*;

   logic [TAIL_W-1:0] tail_reg_ff;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   req_payload_type   in_data_ff;

   // Response register.
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_data_ff;

   logic              req_fire;
   logic              out_free;
   logic              step_fire;
   rsp_payload_type   step_rsp;

   // The response register can be loaded when it is empty or being drained.
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && out_free;

   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !out_free);
   assign out_valid_in = step_fire || (out_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

   // tail_steps register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_reg_ff <= TAIL_STEPS_RESET;
      end else if (csr_wr_en) begin
         tail_reg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_chan.payload;
      end
      if (step_fire) begin
         out_data_ff <= step_rsp;
      end
   end

   mpp_stepper #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .step_fire  (step_fire),
      .step_req   (in_data_ff),
      .tail_steps (tail_reg_ff),
      .step_rsp   (step_rsp)
   );

endmodule
